@@ rtl/pid_fan_duty_controller_assert.svh @@
// Assertion macros used by the checker file of the fan duty controller.
`ifndef PID_FAN_DUTY_CONTROLLER_ASSERT_SVH
`define PID_FAN_DUTY_CONTROLLER_ASSERT_SVH

// Checked on clk, muted while arst_n is low.
`define PFD_ASSERT(lbl, prp, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prp) else $error(msg);

// Checked on clk in every cycle, reset included.
`define PFD_ASSERT_ALWAYS(lbl, prp, msg) \
	lbl: assert property (@(posedge clk) prp) else $error(msg);

`endif

@@ rtl/pfd_pkg.sv @@
// Package: widths, register map, reset values and the control microprogram.
`default_nettype none

package pfd_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int GAIN_W  = 24;
	localparam int MEAS_W  = 16;
	localparam int LIMIT_W = 23;
	localparam int DRIVE_W = 23;
	localparam int MAXC_W  = 16;
	localparam int OFFS_W  = 16;
	localparam int CMP_W   = 17;
	localparam int ERR_W   = MEAS_W + 1;
	localparam int INTEG_W = 24;
	localparam int ACC_W   = 44;

	localparam int APB_DW  = 32;
	localparam int REG_CNT = 8;
	localparam int IDX_W   = $clog2(REG_CNT);
	localparam int PADDR_W = IDX_W + 2;

	localparam logic [IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
	localparam logic [IDX_W-1:0] REG_TARGET      = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_COMPARE = 3'd6;
	localparam logic [IDX_W-1:0] REG_DUTY_OFFSET = 3'd7;

	localparam logic [GAIN_W-1:0]  RST_GAIN_PROP   = 24'd3277;
	localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG  = 24'd33;
	localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV  = 24'd3277;
	localparam logic [MEAS_W-1:0]  RST_TARGET      = 16'd0;
	localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 23'd5242880;
	localparam logic [DRIVE_W-1:0] RST_DRIVE_LIMIT = 23'd6553600;
	localparam logic [MAXC_W-1:0]  RST_MAX_COMPARE = 16'd65535;
	localparam logic [OFFS_W-1:0]  RST_DUTY_OFFSET = 16'd2056;

	localparam logic [CMP_W-1:0] COMPARE_MAX = 17'h1FFFF;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_prop;
		logic [GAIN_W-1:0]  gain_integ;
		logic [GAIN_W-1:0]  gain_deriv;
		logic [MEAS_W-1:0]  target_height;
		logic [LIMIT_W-1:0] integ_limit;
		logic [DRIVE_W-1:0] drive_limit;
		logic [MAXC_W-1:0]  max_compare;
		logic [OFFS_W-1:0]  duty_offset;
	} pfd_cfg_t;

	// multiplier operand select
	localparam logic [2:0] MUL_NONE  = 3'd0;
	localparam logic [2:0] MUL_INTEG = 3'd1;
	localparam logic [2:0] MUL_PROP  = 3'd2;
	localparam logic [2:0] MUL_DERIV = 3'd3;
	localparam logic [2:0] MUL_SCALE = 3'd4;
	localparam logic [2:0] MUL_RECIP = 3'd5;

	// accumulator operation
	localparam logic [2:0] ALU_NOP         = 3'd0;
	localparam logic [2:0] ALU_LOAD_INTEG  = 3'd1;
	localparam logic [2:0] ALU_CLAMP_INTEG = 3'd2;
	localparam logic [2:0] ALU_ACCUM       = 3'd3;
	localparam logic [2:0] ALU_DRIVE       = 3'd4;

	// sequencing
	localparam logic [1:0] SEQ_NEXT     = 2'd0;
	localparam logic [1:0] SEQ_WAIT_IN  = 2'd1;
	localparam logic [1:0] SEQ_WAIT_OUT = 2'd2;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_MUL_I   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_ADD_I   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_CLAMP_I = 4'd3;
	localparam logic [STEP_W-1:0] STEP_ADD_P   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_ADD_D   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_DRIVE   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_SCALE   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_RECIP   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_OUT     = 4'd9;

	typedef struct packed {
		logic [2:0]        mul_op;
		logic [2:0]        alu_op;
		logic              save_prev;
		logic              out_ld;
		logic [1:0]        seq;
		logic [STEP_W-1:0] target;
	} pfd_ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} pfd_cond_t;

	function automatic pfd_ctrl_t pfd_cw(input logic [2:0] mul_op, input logic [2:0] alu_op,
			input logic save_prev, input logic out_ld, input logic [1:0] seq,
			input logic [STEP_W-1:0] target);
		pfd_ctrl_t cw;
		cw.mul_op    = mul_op;
		cw.alu_op    = alu_op;
		cw.save_prev = save_prev;
		cw.out_ld    = out_ld;
		cw.seq       = seq;
		cw.target    = target;
		return cw;
	endfunction

	// Control store: one word per step.
	function automatic pfd_ctrl_t pfd_ucode(input logic [STEP_W-1:0] step);
		pfd_ctrl_t cw;
		case (step)
			STEP_IDLE:    cw = pfd_cw(MUL_NONE,  ALU_NOP,         1'b0, 1'b0, SEQ_WAIT_IN,  STEP_IDLE);
			STEP_MUL_I:   cw = pfd_cw(MUL_INTEG, ALU_NOP,         1'b0, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_ADD_I:   cw = pfd_cw(MUL_NONE,  ALU_LOAD_INTEG,  1'b0, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_CLAMP_I: cw = pfd_cw(MUL_PROP,  ALU_CLAMP_INTEG, 1'b0, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_ADD_P:   cw = pfd_cw(MUL_DERIV, ALU_ACCUM,       1'b0, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_ADD_D:   cw = pfd_cw(MUL_NONE,  ALU_ACCUM,       1'b1, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_DRIVE:   cw = pfd_cw(MUL_NONE,  ALU_DRIVE,       1'b0, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_SCALE:   cw = pfd_cw(MUL_SCALE, ALU_NOP,         1'b0, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_RECIP:   cw = pfd_cw(MUL_RECIP, ALU_NOP,         1'b0, 1'b0, SEQ_NEXT,     STEP_IDLE);
			STEP_OUT:     cw = pfd_cw(MUL_NONE,  ALU_NOP,         1'b0, 1'b1, SEQ_WAIT_OUT, STEP_IDLE);
			default:      cw = pfd_cw(MUL_NONE,  ALU_NOP,         1'b0, 1'b0, SEQ_WAIT_OUT, STEP_IDLE);
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pfd_stream_if.sv @@
// Stream interfaces: measurement beats in, duty result beats out.
`default_nettype none

interface pfd_sample_if;
	logic                       valid;
	logic                       ready;
	logic [pfd_pkg::MEAS_W-1:0] measured_height;

	modport source (output valid, output measured_height, input ready);
	modport sink (input valid, input measured_height, output ready);
endinterface

interface pfd_result_if;
	logic                        valid;
	logic                        ready;
	logic [pfd_pkg::CMP_W-1:0]   pwm_compare;
	logic [pfd_pkg::DRIVE_W-1:0] drive_level;

	modport source (output valid, output pwm_compare, output drive_level, input ready);
	modport sink (input valid, input pwm_compare, input drive_level, output ready);
endinterface

`default_nettype wire

@@ rtl/pfd_regs.sv @@
// APB configuration register file.
`default_nettype none

module pfd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfd_pkg::PADDR_W-1:0]  paddr,
	input  logic [pfd_pkg::APB_DW-1:0]   pwdata,
	output logic [pfd_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output pfd_pkg::pfd_cfg_t            cfg
);
	import pfd_pkg::*;

	pfd_cfg_t         regs_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_prop     <= RST_GAIN_PROP;
			regs_q.gain_integ    <= RST_GAIN_INTEG;
			regs_q.gain_deriv    <= RST_GAIN_DERIV;
			regs_q.target_height <= RST_TARGET;
			regs_q.integ_limit   <= RST_INTEG_LIMIT;
			regs_q.drive_limit   <= RST_DRIVE_LIMIT;
			regs_q.max_compare   <= RST_MAX_COMPARE;
			regs_q.duty_offset   <= RST_DUTY_OFFSET;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_PROP:   regs_q.gain_prop     <= pwdata[GAIN_W-1:0];
				REG_GAIN_INTEG:  regs_q.gain_integ    <= pwdata[GAIN_W-1:0];
				REG_GAIN_DERIV:  regs_q.gain_deriv    <= pwdata[GAIN_W-1:0];
				REG_TARGET:      regs_q.target_height <= pwdata[MEAS_W-1:0];
				REG_INTEG_LIMIT: regs_q.integ_limit   <= pwdata[LIMIT_W-1:0];
				REG_DRIVE_LIMIT: regs_q.drive_limit   <= pwdata[DRIVE_W-1:0];
				REG_MAX_COMPARE: regs_q.max_compare   <= pwdata[MAXC_W-1:0];
				REG_DUTY_OFFSET: regs_q.duty_offset   <= pwdata[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_PROP:   prdata = APB_DW'(regs_q.gain_prop);
			REG_GAIN_INTEG:  prdata = APB_DW'(regs_q.gain_integ);
			REG_GAIN_DERIV:  prdata = APB_DW'(regs_q.gain_deriv);
			REG_TARGET:      prdata = APB_DW'(regs_q.target_height);
			REG_INTEG_LIMIT: prdata = APB_DW'(regs_q.integ_limit);
			REG_DRIVE_LIMIT: prdata = APB_DW'(regs_q.drive_limit);
			REG_MAX_COMPARE: prdata = APB_DW'(regs_q.max_compare);
			REG_DUTY_OFFSET: prdata = APB_DW'(regs_q.duty_offset);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/pfd_useq.sv @@
// Microprogram sequencer: step counter, control store lookup, wait jumps.
`default_nettype none

module pfd_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  pfd_pkg::pfd_cond_t cond,
	output pfd_pkg::pfd_ctrl_t cw
);
	import pfd_pkg::*;

	logic [STEP_W-1:0] pc_q;

	assign cw = pfd_ucode(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			case (cw.seq)
				SEQ_NEXT:     pc_q <= pc_q + 1'b1;
				SEQ_WAIT_IN:  if (cond.in_valid) pc_q <= pc_q + 1'b1;
				SEQ_WAIT_OUT: if (cond.out_free) pc_q <= cw.target;
				default:      pc_q <= STEP_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/pfd_dpath.sv @@
// PID datapath: shared multiplier, 44-bit accumulator, clamps, output register.
`default_nettype none

module pfd_dpath #(
	parameter int FRAC_BITS = pfd_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfd_pkg::pfd_cfg_t           cfg,
	input  pfd_pkg::pfd_ctrl_t          cw,
	input  logic                        in_acc,
	input  logic [pfd_pkg::MEAS_W-1:0]  meas,
	output logic                        out_free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pfd_pkg::CMP_W-1:0]   pwm_compare,
	output logic [pfd_pkg::DRIVE_W-1:0] drive_level
);
	import pfd_pkg::*;

	// drive * max_compare >> FRAC_BITS, then /100 by reciprocal: y*RECIP >> K
	localparam int YW     = DRIVE_W + MAXC_W - FRAC_BITS;
	localparam int K      = YW + 7;
	localparam int RW     = K - 6;
	localparam int MUL_W  = (RW > GAIN_W) ? RW : GAIN_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int QW     = YW;
	localparam int SUM_W  = ((QW > OFFS_W) ? QW : OFFS_W) + 1;
	localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) + 64'd99) / 64'd100);

	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [PROD_W-1:0]         prod_q;
	logic                      neg_q;
	logic [DRIVE_W-1:0]        drive_q;
	logic                      out_valid_q;
	logic [CMP_W-1:0]          pwm_q;
	logic [DRIVE_W-1:0]        lvl_q;

	logic signed [ERR_W:0]     derr;
	logic [ERR_W-1:0]          err_neg;
	logic [ERR_W-2:0]          err_mag;
	logic [ERR_W:0]            derr_neg;
	logic [ERR_W-1:0]          derr_mag;
	logic [MUL_W-1:0]          mul_a;
	logic [MUL_W-1:0]          mul_b;
	logic                      mul_en;
	logic                      sign_en;
	logic                      sign_nxt;
	logic signed [ACC_W-1:0]   term;
	logic signed [ACC_W-1:0]   sprod;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   acc_add;
	logic signed [ACC_W-1:0]   lim_p;
	logic signed [ACC_W-1:0]   lim_n;
	logic signed [ACC_W-1:0]   integ_clamp;
	logic [ACC_W-1:0]          acc_neg;
	logic [ACC_W-1:0]          acc_mag;
	logic [DRIVE_W-1:0]        drive_nxt;
	logic [QW-1:0]             quot;
	logic [SUM_W-1:0]          cmp_sum;
	logic [CMP_W-1:0]          cmp_sat;
	logic                      out_ld;

	assign derr     = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
	assign err_neg  = -err_q;
	assign err_mag  = err_q[ERR_W-1] ? err_neg[ERR_W-2:0] : err_q[ERR_W-2:0];
	assign derr_neg = -derr;
	assign derr_mag = derr[ERR_W] ? derr_neg[ERR_W-1:0] : derr[ERR_W-1:0];

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_en   = 1'b1;
		sign_en  = 1'b0;
		sign_nxt = 1'b0;
		case (cw.mul_op)
			MUL_INTEG: begin
				mul_a    = MUL_W'(err_mag);
				mul_b    = MUL_W'(cfg.gain_integ);
				sign_en  = 1'b1;
				sign_nxt = err_q[ERR_W-1];
			end
			MUL_PROP: begin
				mul_a    = MUL_W'(err_mag);
				mul_b    = MUL_W'(cfg.gain_prop);
				sign_en  = 1'b1;
				sign_nxt = err_q[ERR_W-1];
			end
			MUL_DERIV: begin
				mul_a    = MUL_W'(derr_mag);
				mul_b    = MUL_W'(cfg.gain_deriv);
				sign_en  = 1'b1;
				sign_nxt = derr[ERR_W];
			end
			MUL_SCALE: begin
				mul_a = MUL_W'(drive_q);
				mul_b = MUL_W'(cfg.max_compare);
			end
			MUL_RECIP: begin
				mul_a = MUL_W'(prod_q >> FRAC_BITS);
				mul_b = MUL_W'(RECIP);
			end
			default: mul_en = 1'b0;
		endcase
	end

	// signed product of the last term; products stay below 2^43
	assign term    = {1'b0, prod_q[ACC_W-2:0]};
	assign sprod   = neg_q ? -term : term;
	assign base    = (cw.alu_op == ALU_LOAD_INTEG) ? ACC_W'(integ_q) : acc_q;
	assign acc_add = base + sprod;

	assign lim_p       = $signed(ACC_W'(cfg.integ_limit));
	assign lim_n       = -lim_p;
	assign integ_clamp = (acc_q > lim_p) ? lim_p : ((acc_q < lim_n) ? lim_n : acc_q);

	assign acc_neg   = -acc_q;
	assign acc_mag   = acc_q[ACC_W-1] ? acc_neg : acc_q;
	assign drive_nxt = (acc_mag > ACC_W'(cfg.drive_limit)) ? cfg.drive_limit
	                                                      : acc_mag[DRIVE_W-1:0];

	assign quot    = QW'(prod_q >> K);
	assign cmp_sum = SUM_W'(quot) + SUM_W'(cfg.duty_offset);
	assign cmp_sat = (cmp_sum > SUM_W'(COMPARE_MAX)) ? COMPARE_MAX : cmp_sum[CMP_W-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign out_ld   = cw.out_ld && out_free;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q <= $signed({1'b0, cfg.target_height}) - $signed({1'b0, meas});
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (sign_en) begin
			neg_q <= sign_nxt;
		end
		case (cw.alu_op)
			ALU_LOAD_INTEG:  acc_q   <= acc_add;
			ALU_CLAMP_INTEG: acc_q   <= integ_clamp;
			ALU_ACCUM:       acc_q   <= acc_add;
			ALU_DRIVE:       drive_q <= drive_nxt;
			default: ;
		endcase
		if (out_ld) begin
			pwm_q <= cmp_sat;
			lvl_q <= drive_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cw.alu_op == ALU_CLAMP_INTEG) begin
				integ_q <= INTEG_W'(integ_clamp);
			end
			if (cw.save_prev) begin
				prev_q <= err_q;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pwm_compare = pwm_q;
	assign drive_level = lvl_q;

endmodule

`default_nettype wire

@@ rtl/pid_fan_duty_controller.sv @@
// Result beat goes valid when step 9 loads the output register after a measurement beat.
// Throughput: one measurement per pass of the ten-step control program, set by
//   the single shared multiplier; a stalled result only holds step 9.
// A finished result sits in its output register while the next beat is taken.
// Reset: arst_n clears registers to their defaults, integrator and previous error
//   to zero, and parks the sequencer on its idle step; no clearing pass.
`default_nettype none

module pid_fan_duty_controller #(
	parameter int FRAC_BITS = pfd_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfd_pkg::PADDR_W-1:0]  paddr,
	input  logic [pfd_pkg::APB_DW-1:0]   pwdata,
	output logic [pfd_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	pfd_sample_if.sink                   sample,
	pfd_result_if.source                 result
);
	import pfd_pkg::*;

	pfd_cfg_t  cfg;
	pfd_ctrl_t cw;
	pfd_cond_t cond;
	logic      in_acc;
	logic      out_free;

	// Config registers. Writes are only expected between ticks, so the
	// datapath reads them live without shadowing.
	pfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A measurement beat is only taken on the idle step; the same edge
	// latches the error (set point minus measurement) into the datapath.
	assign sample.ready  = (cw.seq == SEQ_WAIT_IN);
	assign in_acc        = sample.valid && sample.ready;
	assign cond.in_valid = sample.valid;
	assign cond.out_free = out_free;

	// Program, one step each:
	//   1 integral product   2 integral add     3 integral clamp, P product
	//   4 add P, D product   5 add D, save err  6 magnitude and drive clamp
	//   7 drive * max_compare                   8 /100 by reciprocal
	//   9 offset, saturate, load output register (waits while it is full)
	pfd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.cw     (cw)
	);

	pfd_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cw          (cw),
		.in_acc      (in_acc),
		.meas        (sample.measured_height),
		.out_free    (out_free),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.pwm_compare (result.pwm_compare),
		.drive_level (result.drive_level)
	);

endmodule

`default_nettype wire

@@ rtl/pfd_chk.sv @@
// Port-level checker for the fan duty controller, bound to the top level.
`default_nettype none

`include "pid_fan_duty_controller_assert.svh"

module pfd_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        sample_valid,
	input wire logic                        sample_ready,
	input wire logic                        result_valid,
	input wire logic                        result_ready,
	input wire logic [pfd_pkg::CMP_W-1:0]   pwm_compare,
	input wire logic [pfd_pkg::DRIVE_W-1:0] drive_level
);

	// stalled result beat holds
	`PFD_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(pwm_compare) && $stable(drive_level), "result beat changed while stalled")

	// one tick in flight at a time
	`PFD_ASSERT(a_one_in_flight, sample_valid && sample_ready |=> !sample_ready, "second beat taken during a tick")

	// a fresh result traces back to the measurement beat that started its tick
	`PFD_ASSERT(a_result_latency, $rose(result_valid) |-> $past(sample_valid && sample_ready, 10), "result without matching measurement")

	// no result once a reset edge has gone by
	`PFD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid, "result valid during reset")

endmodule

bind pid_fan_duty_controller pfd_chk u_pfd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.pwm_compare  (result.pwm_compare),
	.drive_level  (result.drive_level)
);

`default_nettype wire

@@ dv/pid_fan_duty_controller_test.sv @@
// Self-checking bench for the PID fan duty controller: APB setup, height beats, duty checks.
module pid_fan_duty_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfd_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 5;
	localparam int IDLE_LIMIT      = 4000;  // cycles with no beat before the run is abandoned
	localparam int SETTLE_CYCLES   = 4;     // pause after the last result, before new settings
	localparam int DRAIN_CYCLES    = 20;    // wait for stray result beats before closing
	localparam int RANDOM_PHASES   = 12;
	localparam int BEATS_PER_PHASE = 136;
	// 100 percent drive in Q.16
	localparam longint FULL_SCALE  = 64'd100 << FRAC_BITS_DEF;

	typedef struct packed {
		logic [CMP_W-1:0]   pwm_compare;
		logic [DRIVE_W-1:0] drive_level;
	} duty_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	pfd_sample_if sample_ch();
	pfd_result_if result_ch();

	pid_fan_duty_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_ch),
		.result  (result_ch)
	);

	// Bench copy of the register file, loop state and the beat queues.
	pfd_cfg_t                   cfg;
	logic signed [INTEG_W-1:0]  integ_acc = '0;  // clamped integral term
	logic signed [ERR_W-1:0]    last_err  = '0;  // error of the previous tick
	logic [MEAS_W-1:0]          heights[$];      // measurements not yet sent
	duty_t                      expected_duty[$];

	int   gap_pct;     // chance in percent that the sender holds back a beat
	int   stall_pct;   // chance in percent that the receiver drops ready
	logic in_fire = 1'b0;
	int   errors = 0;
	int   beats_in = 0;
	int   results_seen = 0;
	int   settings = 0;
	int   reversed = 0;
	int   saturated = 0;
	int   quiet_cycles = 0;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic pfd_cfg_t default_setting();
		pfd_cfg_t s;
		s.gain_prop     = RST_GAIN_PROP;
		s.gain_integ    = RST_GAIN_INTEG;
		s.gain_deriv    = RST_GAIN_DERIV;
		s.target_height = RST_TARGET;
		s.integ_limit   = RST_INTEG_LIMIT;
		s.drive_limit   = RST_DRIVE_LIMIT;
		s.max_compare   = RST_MAX_COMPARE;
		s.duty_offset   = RST_DUTY_OFFSET;
		return s;
	endfunction

	// One in ten picks zero, one in ten the top of the field, the rest a typical value.
	function automatic logic [APB_DW-1:0] pick_value(input int unsigned top, input int unsigned typ);
		case ($urandom_range(9))
			0: begin
				return '0;
			end
			1: begin
				return top;
			end
			default: begin
				return $urandom_range(typ);
			end
		endcase
	endfunction

	function automatic pfd_cfg_t random_setting();
		pfd_cfg_t s;
		// gains mostly below 2.0 so the loop is not always pinned at the drive limit
		s.gain_prop     = GAIN_W'(pick_value(32'hFFFFFF, 131072));
		s.gain_integ    = GAIN_W'(pick_value(32'hFFFFFF, 131072));
		s.gain_deriv    = GAIN_W'(pick_value(32'hFFFFFF, 131072));
		s.target_height = MEAS_W'(pick_value(32'hFFFF, 32'hFFFF));
		s.integ_limit   = LIMIT_W'(pick_value(32'h7FFFFF, 32'h7FFFFF));
		// the top pick lies above 100 percent, which lets the compare saturate
		s.drive_limit   = DRIVE_W'(pick_value(32'h7FFFFF, 6553600));
		s.max_compare   = MAXC_W'(pick_value(32'hFFFF, 32'hFFFF));
		s.duty_offset   = OFFS_W'(pick_value(32'hFFFF, 32'hFFFF));
		return s;
	endfunction

	function automatic logic [APB_DW-1:0] reg_value(input logic [IDX_W-1:0] idx);
		case (idx)
			REG_GAIN_PROP: begin
				return APB_DW'(cfg.gain_prop);
			end
			REG_GAIN_INTEG: begin
				return APB_DW'(cfg.gain_integ);
			end
			REG_GAIN_DERIV: begin
				return APB_DW'(cfg.gain_deriv);
			end
			REG_TARGET: begin
				return APB_DW'(cfg.target_height);
			end
			REG_INTEG_LIMIT: begin
				return APB_DW'(cfg.integ_limit);
			end
			REG_DRIVE_LIMIT: begin
				return APB_DW'(cfg.drive_limit);
			end
			REG_MAX_COMPARE: begin
				return APB_DW'(cfg.max_compare);
			end
			default: begin
				return APB_DW'(cfg.duty_offset);
			end
		endcase
	endfunction

	// One control tick: error, PID terms with the integral clamp, magnitude, drive clamp,
	// compare scaling with saturation. Pushes the duty the block must return.
	function automatic void predict_duty(input logic [MEAS_W-1:0] height);
		longint err;
		longint lim;
		longint integ;
		longint ctrl;
		longint drive;
		longint scaled;
		duty_t  d;
		err   = longint'(cfg.target_height) - longint'(height);
		lim   = longint'(cfg.integ_limit);
		integ = longint'(integ_acc) + err * longint'(cfg.gain_integ);
		if (integ > lim) begin
			integ = lim;
		end else if (integ < -lim) begin
			integ = -lim;
		end
		ctrl = err * longint'(cfg.gain_prop) + integ
			+ (err - longint'(last_err)) * longint'(cfg.gain_deriv);
		if (ctrl < 0) begin
			ctrl = -ctrl;
			reversed++;
		end
		drive = (ctrl > longint'(cfg.drive_limit)) ? longint'(cfg.drive_limit) : ctrl;
		scaled = drive * longint'(cfg.max_compare) / FULL_SCALE + longint'(cfg.duty_offset);
		if (scaled > longint'(COMPARE_MAX)) begin
			scaled = longint'(COMPARE_MAX);
			saturated++;
		end
		integ_acc = integ[INTEG_W-1:0];
		last_err  = err[ERR_W-1:0];
		d.pwm_compare = scaled[CMP_W-1:0];
		d.drive_level = drive[DRIVE_W-1:0];
		expected_duty.push_back(d);
	endfunction

	// APB write: setup cycle, then access cycle; the register takes the value at the
	// rising edge that ends the access cycle.
	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// APB read; prdata is taken at the edge that closes the access cycle.
	task automatic reg_read_check(input logic [IDX_W-1:0] idx);
		logic [APB_DW-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== reg_value(idx)) begin
			errors++;
			$error("register %0d readback: expected %0h, got %0h", idx, reg_value(idx), got);
		end
	endtask

	// Writes every register, then reads them all back.
	task automatic apply_setting(input pfd_cfg_t s);
		reg_write(REG_GAIN_PROP,   APB_DW'(s.gain_prop));
		reg_write(REG_GAIN_INTEG,  APB_DW'(s.gain_integ));
		reg_write(REG_GAIN_DERIV,  APB_DW'(s.gain_deriv));
		reg_write(REG_TARGET,      APB_DW'(s.target_height));
		reg_write(REG_INTEG_LIMIT, APB_DW'(s.integ_limit));
		reg_write(REG_DRIVE_LIMIT, APB_DW'(s.drive_limit));
		reg_write(REG_MAX_COMPARE, APB_DW'(s.max_compare));
		reg_write(REG_DUTY_OFFSET, APB_DW'(s.duty_offset));
		cfg = s;
		settings++;
		for (int i = 0; i < REG_CNT; i++) begin
			reg_read_check(IDX_W'(i));
		end
		// hand over on a rising edge so the sender never races the queue fill
		@(posedge clk);
	endtask

	// Sampled on the rising edge: valid is stable there, and a beat taken at this edge
	// keeps valid high, so the loop cannot end with a tick still unpredicted.
	task automatic wait_for_results();
		while (heights.size() != 0 || sample_ch.valid || expected_duty.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Height sender. A new beat is offered only once the current one was taken.
	// Result receiver: ready rolled every cycle.
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			result_ch.ready <= 1'b0;
		end else begin
			if (!sample_ch.valid || in_fire) begin
				if (heights.size() != 0 && $urandom_range(99) >= gap_pct) begin
					sample_ch.valid           <= 1'b1;
					sample_ch.measured_height <= heights.pop_front();
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: checks each result beat against the oldest prediction, then runs the
	// predictor for a height beat taken at the same edge.
	always @(posedge clk) begin
		duty_t want;
		in_fire <= arst_n && sample_ch.valid && sample_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (expected_duty.size() == 0) begin
				errors++;
				$error("duty beat with no tick outstanding: pwm_compare %0d, drive_level %0d",
					result_ch.pwm_compare, result_ch.drive_level);
			end else begin
				want = expected_duty.pop_front();
				if (result_ch.pwm_compare !== want.pwm_compare) begin
					errors++;
					$error("pwm_compare: expected %0d, got %0d",
						want.pwm_compare, result_ch.pwm_compare);
				end
				if (result_ch.drive_level !== want.drive_level) begin
					errors++;
					$error("drive_level: expected %0d, got %0d",
						want.drive_level, result_ch.drive_level);
				end
			end
		end
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			beats_in++;
			predict_duty(sample_ch.measured_height);
		end
	end

	// Watchdog: too long without any beat on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("pid_fan_duty_controller_test: FAIL");
			$finish;
		end
	end

	initial begin
		pfd_cfg_t s;
		int       span;
		int       pos;
		cfg                       = default_setting();
		arst_n                    = 1'b0;
		psel                      = 1'b0;
		penable                   = 1'b0;
		pwrite                    = 1'b0;
		paddr                     = '0;
		pwdata                    = '0;
		sample_ch.valid           = 1'b0;
		sample_ch.measured_height = '0;
		result_ch.ready           = 1'b0;
		// light sender gaps, heavy receiver stalls for the directed part and first third
		gap_pct   = 8;
		stall_pct = 73;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset values must read back before anything is written
		for (int i = 0; i < REG_CNT; i++) begin
			reg_read_check(IDX_W'(i));
		end

		// Defaults, target zero: every nonzero height gives a negative control sum.
		apply_setting(default_setting());
		heights = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1};
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Everything at its top: largest error, derivative term both ways, integral clamp
		// hit on the high side, drive limit above 100 percent, compare saturated.
		s.gain_prop     = 24'hFFFFFF;
		s.gain_integ    = 24'hFFFFFF;
		s.gain_deriv    = 24'hFFFFFF;
		s.target_height = 16'hFFFF;
		s.integ_limit   = 23'h7FFFFF;
		s.drive_limit   = 23'h7FFFFF;
		s.max_compare   = 16'hFFFF;
		s.duty_offset   = 16'hFFFF;
		apply_setting(s);
		heights = '{16'd0, 16'hFFFF, 16'd0, 16'd32768};
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Zero integral and drive limits: drive stays zero, compare is just the offset.
		s.target_height = 16'd32768;
		s.integ_limit   = '0;
		s.drive_limit   = '0;
		s.duty_offset   = 16'd4660;
		apply_setting(s);
		heights = '{16'd0, 16'hFFFF, 16'd32768};
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Unit P and I gains, half D gain, around a set point: unsaturated terms, integral against a small
		// clamp, compare scaling with a truncated fraction.
		s.gain_prop     = 24'd65536;
		s.gain_integ    = 24'd65536;
		s.gain_deriv    = 24'd32768;
		s.target_height = 16'd1000;
		s.integ_limit   = 23'd655360;
		s.drive_limit   = 23'd6553600;
		s.max_compare   = 16'd50000;
		s.duty_offset   = '0;
		apply_setting(s);
		heights = '{16'd990, 16'd1000, 16'd1010, 16'd1020, 16'd1000, 16'd995};
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Random settings. Heights mostly follow a drifting walk toward the set point, as a
		// levitated object would; the rest are settled ticks and full-range noise.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == RANDOM_PHASES / 3) begin
				gap_pct   = 73;
				stall_pct = 8;
			end else if (ph == 2 * RANDOM_PHASES / 3) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			apply_setting(random_setting());
			span = 1 << $urandom_range(12);
			pos  = int'(cfg.target_height);
			repeat (BEATS_PER_PHASE) begin
				case ($urandom_range(9))
					0: begin
						pos = $urandom_range(32'hFFFF);
					end
					1: begin
						pos = int'(cfg.target_height);
					end
					default: begin
						pos = pos + int'($urandom_range(2 * span)) - span
							+ (int'(cfg.target_height) - pos) / 8;
					end
				endcase
				if (pos < 0) begin
					pos = 0;
				end else if (pos > 16'hFFFF) begin
					pos = 16'hFFFF;
				end
				heights.push_back(MEAS_W'(pos));
			end
			wait_for_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		// last tick is predicted; let any stray beat show up before closing
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d duty beats for %0d height beats over %0d register settings.",
			results_seen, beats_in, settings);
		$display("%0d ticks had a negative control sum, %0d compares saturated.",
			reversed, saturated);
		if (errors == 0) begin
			$display("pid_fan_duty_controller_test: PASS");
		end else begin
			$display("pid_fan_duty_controller_test: FAIL");
		end
		$finish;
	end

endmodule
